// ===== hw/rtl/range_min_max_tree_unit_assert.svh =====
// Assertion macros for the range min/max tree unit.
`ifndef RANGE_MIN_MAX_TREE_UNIT_ASSERT_SVH
`define RANGE_MIN_MAX_TREE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RMMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RMMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rmmt_pkg.sv =====
`default_nettype none
package rmmt_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 3;
    localparam int IDXA_W  = 10;
    localparam int IDXB_W  = 11;
    localparam int SIZE_W  = 11;

    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FWD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BWD   = 3'd4;

    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDXA_W-1:0]  index_a;
        logic [IDXB_W-1:0]  index_b;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic [IDXA_W-1:0]  result_index;
        logic               found;
    } rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rmmt_mem.sv =====
`default_nettype none
module rmmt_mem #(
    parameter int DEPTH = 2088,
    parameter int DW = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/range_min_max_tree_unit.sv =====
//  channel   | direction | handshake                    | payload
//  request   | in        | start & !busy                | req (cmd, index_a, index_b, value)
//  result    | out       | result_valid, one cycle      | result (value, index, found)
//  config    | in        | cfg_valid & cfg_ready        | cfg_index, cfg_data
//
//  A node access sends the address, then uses the registered read data from the store's one read port.
//  Write: leaf write, then per level read sibling, combine, write parent unless unchanged.
//  Query: combines edge nodes per level. Search: up, then down. Rebuild: each node from its children.
//  After reset a clearing pass zeroes all 2*MAX_LEAVES+40 store words with busy high.
//  Results cannot be stalled; a new request is taken in the cycle a result is shown.
`default_nettype none
module range_min_max_tree_unit #(
    parameter int MAX_LEAVES = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rmmt_pkg::req_t req,
    output logic               result_valid,
    output rmmt_pkg::rsp_t     result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [10:0]   cfg_data
);
    import rmmt_pkg::*;

    localparam int DEPTH    = 2 * MAX_LEAVES + 40;
    localparam int AW       = $clog2(DEPTH);
    localparam int IW       = ($clog2(MAX_LEAVES) + 2 > 11) ? $clog2(MAX_LEAVES) + 2 : 11;
    localparam int LVW      = $clog2($clog2(MAX_LEAVES) + 3);
    localparam int NODE_OFF = MAX_LEAVES;

    typedef enum logic [17:0] {
        S_CLEAR = 18'h00001,
        S_IDLE  = 18'h00002,
        S_WLEAF = 18'h00004,
        S_WSIBR = 18'h00008,
        S_WSIB  = 18'h00010,
        S_WPAR  = 18'h00020,
        S_BRD0  = 18'h00040,
        S_BRD1  = 18'h00080,
        S_BWR   = 18'h00100,
        S_QRES  = 18'h00200,
        S_QLOOP = 18'h00400,
        S_QA    = 18'h00800,
        S_QB    = 18'h01000,
        S_QBU   = 18'h02000,
        S_SUP   = 18'h04000,
        S_SUPC  = 18'h08000,
        S_SDN   = 18'h10000,
        S_SDNC  = 18'h20000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [SIZE_W-1:0]    size_reg;
    logic                 max_reg;
    logic                 res_valid_reg, res_valid_next;
    rsp_t                 res_reg, res_next;
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [IW-1:0]        base_reg, base_next;
    logic [IW-1:0]        cbase_reg, cbase_next;
    logic [IW-1:0]        ia_reg, ia_next;
    logic [IW-1:0]        ib_reg, ib_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   cur_reg, cur_next;
    logic                 bwd_reg, bwd_next;
    logic                 rd_ok_reg;

    logic [IW-1:0]        m_eff, m_less;
    logic [LVW-1:0]       top;
    logic [IW-1:0]        size_cur, size_dn, size_rd;
    logic [IW-1:0]        base_up, base_dn;
    logic [LVW-1:0]       lvl_up, lvl_dn;

    logic [LVW-1:0]       rd_lvl;
    logic [IW-1:0]        rd_base, rd_idx;
    logic                 rd_ok;
    logic [AW-1:0]        rd_addr;
    logic [VALUE_W-1:0]   mem_q, rdata;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;

    logic [VALUE_W-1:0]   cmp_x, cmp_y, best;
    logic                 prefer;
    logic [IW-1:0]        i2;

    function automatic logic [IW-1:0] size_of(input logic [IW-1:0] mm, input logic [LVW-1:0] l);
        logic [IW-1:0] mask;
        mask = ~({IW{1'b1}} << l);
        return (mm >> l) + IW'(|(mm & mask));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic leaf, input logic [IW-1:0] b,
                                              input logic [IW-1:0] i);
        return leaf ? AW'(i) : AW'(NODE_OFF) + AW'(b) + AW'(i);
    endfunction

    // effective leaf count and tree height
    always_comb
    begin
        if (size_reg == '0)
        begin
            m_eff = IW'(1);
        end
        else if (IW'(size_reg) > IW'(MAX_LEAVES))
        begin
            m_eff = IW'(MAX_LEAVES);
        end
        else
        begin
            m_eff = IW'(size_reg);
        end
        m_less = m_eff - IW'(1);
        top = '0;
        for (int k = 0; k < IW; k++)
        begin
            if (m_less[k])
            begin
                top = LVW'(k + 1);
            end
        end
    end

    assign lvl_up   = lvl_reg + LVW'(1);
    assign lvl_dn   = lvl_reg - LVW'(1);
    assign size_cur = size_of(m_eff, lvl_reg);
    assign size_dn  = size_of(m_eff, lvl_dn);
    assign size_rd  = size_of(m_eff, rd_lvl);
    assign base_up  = (lvl_reg == '0) ? '0 : base_reg + size_cur;
    assign base_dn  = (lvl_dn == '0) ? '0 : base_reg - size_dn;
    assign i2       = ia_reg << 1;

    assign rd_ok   = (rd_lvl == '0) ? (rd_idx < IW'(MAX_LEAVES))
                                    : ((rd_lvl <= top) && (rd_idx < size_rd));
    assign rd_addr = addr_of(rd_lvl == '0, rd_base, rd_idx);
    assign rdata   = rd_ok_reg ? mem_q : '0;

    // shared compare unit: combine for min/max, match for searches
    always_comb
    begin
        if ((state_reg == S_SUPC) || (state_reg == S_SDNC))
        begin
            cmp_x = rdata;
            cmp_y = val_reg;
        end
        else
        begin
            cmp_x = cur_reg;
            cmp_y = rdata;
        end
        prefer = max_reg ? (cmp_x >= cmp_y) : (cmp_x <= cmp_y);
        best   = prefer ? cmp_x : cmp_y;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        lvl_next       = lvl_reg;
        base_next      = base_reg;
        cbase_next     = cbase_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        bwd_next       = bwd_reg;
        rd_lvl         = lvl_reg;
        rd_base        = base_reg;
        rd_idx         = ia_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_lvl  = '0;
                rd_base = '0;
                rd_idx  = IW'(req.index_a);
                if (start)
                begin
                    lvl_next  = '0;
                    base_next = '0;
                    ia_next   = IW'(req.index_a);
                    val_next  = req.value;
                    case (req.cmd)
                        CMD_WRITE:
                        begin
                            cur_next   = req.value;
                            state_next = S_WLEAF;
                        end
                        CMD_BUILD:
                        begin
                            lvl_next   = LVW'(1);
                            cbase_next = '0;
                            ia_next    = '0;
                            if (top != '0)
                            begin
                                state_next = S_BRD0;
                            end
                        end
                        CMD_QUERY:
                        begin
                            ib_next    = (IW'(req.index_b) > m_eff) ? m_eff : IW'(req.index_b);
                            state_next = S_QRES;
                        end
                        CMD_FWD:
                        begin
                            bwd_next   = 1'b0;
                            state_next = S_SUP;
                        end
                        CMD_BWD:
                        begin
                            bwd_next   = 1'b1;
                            state_next = S_SUP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WLEAF:
            begin
                wr_en   = ia_reg < IW'(MAX_LEAVES);
                wr_addr = addr_of(1'b1, '0, ia_reg);
                wr_data = val_reg;
                if ((ia_reg >= IW'(MAX_LEAVES)) || (ia_reg >= m_eff) || (top == '0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WSIBR;
                end
            end
            S_WSIBR:
            begin
                rd_idx     = ia_reg ^ IW'(1);
                state_next = S_WSIB;
            end
            S_WSIB:
            begin
                if ((ia_reg ^ IW'(1)) < size_cur)
                begin
                    cur_next = best;
                end
                rd_lvl     = lvl_up;
                rd_base    = base_up;
                rd_idx     = ia_reg >> 1;
                state_next = S_WPAR;
            end
            S_WPAR:
            begin
                if (rdata == cur_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = addr_of(1'b0, base_up, ia_reg >> 1);
                    wr_data   = cur_reg;
                    lvl_next  = lvl_up;
                    base_next = base_up;
                    ia_next   = ia_reg >> 1;
                    state_next = (lvl_up < top) ? S_WSIBR : S_IDLE;
                end
            end
            S_BRD0:
            begin
                rd_lvl     = lvl_dn;
                rd_base    = cbase_reg;
                rd_idx     = i2;
                state_next = S_BRD1;
            end
            S_BRD1:
            begin
                cur_next   = rdata;
                rd_lvl     = lvl_dn;
                rd_base    = cbase_reg;
                rd_idx     = i2 + IW'(1);
                state_next = S_BWR;
            end
            S_BWR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(1'b0, base_reg, ia_reg);
                wr_data = ((i2 + IW'(1)) < size_dn) ? best : cur_reg;
                if ((ia_reg + IW'(1)) == size_cur)
                begin
                    lvl_next   = lvl_up;
                    cbase_next = base_reg;
                    base_next  = base_reg + size_cur;
                    ia_next    = '0;
                    state_next = (lvl_up > top) ? S_IDLE : S_BRD0;
                end
                else
                begin
                    ia_next    = ia_reg + IW'(1);
                    state_next = S_BRD0;
                end
            end
            S_QRES:
            begin
                cur_next   = rdata;
                state_next = S_QLOOP;
            end
            S_QLOOP:
            begin
                if (ia_reg >= ib_reg)
                begin
                    res_valid_next        = 1'b1;
                    res_next.result_value = cur_reg;
                    res_next.result_index = '0;
                    res_next.found        = 1'b0;
                    state_next            = S_IDLE;
                end
                else if (ia_reg[0])
                begin
                    state_next = S_QA;
                end
                else
                begin
                    state_next = S_QB;
                end
            end
            S_QA:
            begin
                cur_next   = best;
                ia_next    = ia_reg + IW'(1);
                state_next = S_QB;
            end
            S_QB:
            begin
                if (ib_reg[0])
                begin
                    rd_idx     = ib_reg - IW'(1);
                    ib_next    = ib_reg - IW'(1);
                    state_next = S_QBU;
                end
                else
                begin
                    ia_next    = ia_reg >> 1;
                    ib_next    = ib_reg >> 1;
                    lvl_next   = lvl_up;
                    base_next  = base_up;
                    state_next = S_QLOOP;
                end
            end
            S_QBU:
            begin
                cur_next   = best;
                ia_next    = ia_reg >> 1;
                ib_next    = ib_reg >> 1;
                lvl_next   = lvl_up;
                base_next  = base_up;
                state_next = S_QLOOP;
            end
            S_SUP:
            begin
                if (ia_reg >= size_cur)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SUPC;
                end
            end
            S_SUPC:
            begin
                if (prefer)
                begin
                    state_next = S_SDN;
                end
                else if (ia_reg[0] != bwd_reg)
                begin
                    // step along the level: forward from odd, backward from even
                    if (bwd_reg && (ia_reg == '0))
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ia_next    = bwd_reg ? ia_reg - IW'(1) : ia_reg + IW'(1);
                        state_next = S_SUP;
                    end
                end
                else if (lvl_reg >= top)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ia_next    = ia_reg >> 1;
                    lvl_next   = lvl_up;
                    base_next  = base_up;
                    state_next = S_SUP;
                end
            end
            S_SDN:
            begin
                if (lvl_reg == '0)
                begin
                    res_valid_next        = 1'b1;
                    res_next.result_value = '0;
                    res_next.result_index = ia_reg[IDXA_W-1:0];
                    res_next.found        = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    rd_lvl     = lvl_dn;
                    rd_base    = base_dn;
                    rd_idx     = bwd_reg ? i2 + IW'(1) : i2;
                    lvl_next   = lvl_dn;
                    base_next  = base_dn;
                    ia_next    = i2;
                    state_next = S_SDNC;
                end
            end
            S_SDNC:
            begin
                if (((ia_reg + IW'(1)) < size_cur) && (prefer == bwd_reg))
                begin
                    ia_next = ia_reg + IW'(1);
                end
                state_next = S_SDN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            size_reg      <= 11'd1024;
            max_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE: size_reg <= cfg_data;
                    REG_MODE: max_reg  <= cfg_data[0];
                    default:  size_reg <= size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        lvl_reg   <= lvl_next;
        base_reg  <= base_next;
        cbase_reg <= cbase_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        val_reg   <= val_next;
        cur_reg   <= cur_next;
        bwd_reg   <= bwd_next;
        rd_ok_reg <= rd_ok;
    end

    rmmt_mem #(
        .DEPTH (DEPTH),
        .DW    (VALUE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE) && !start;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`include "range_min_max_tree_unit_assert.svh"

    `RMMT_ASSERT_NOW(a_result_after_work, result_valid, $past(busy), "result without a request in flight")
    `RMMT_ASSERT_NOW(a_miss_index_zero, result_valid && !result.found, result.result_index == '0, "miss reports a nonzero index")
    `RMMT_ASSERT_NEXT(a_query_goes_busy, start && !busy && (req.cmd == CMD_QUERY), busy, "query request did not start")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rmmt_pkg::*;

    localparam int LEAVES = 1024;
    localparam int SETTLE = 100000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic result_valid;
    rsp_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;

    range_min_max_tree_unit #(.MAX_LEAVES(LEAVES)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mirror of the tree
    logic [31:0] leaves [LEAVES];
    logic [31:0] nodes [LEAVES + 40];
    int unsigned lv_size [40];
    int unsigned lv_base [40];
    int unsigned lv_top;
    logic [10:0] tree_size;
    logic        max_mode;

    rsp_t answers [$];
    int   errors = 0;
    int   send_idle = 0;

    function automatic void plan();
        int unsigned m, off;
        m = tree_size;
        off = 0;
        if (m < 1) m = 1;
        if (m > LEAVES) m = LEAVES;
        lv_size[0] = m;
        lv_base[0] = 0;
        lv_top = 0;
        while (m > 1 && lv_top < 38)
        begin
            m = (m >> 1) + (m & 1);
            lv_top++;
            lv_size[lv_top] = m;
            lv_base[lv_top] = off;
            off += m;
        end
    endfunction

    function automatic logic [31:0] node_rd(int unsigned l, int unsigned i);
        if (l == 0) return (i < LEAVES) ? leaves[i] : 32'd0;
        if (l > lv_top || i >= lv_size[l]) return 32'd0;
        return nodes[lv_base[l] + i];
    endfunction

    function automatic void node_wr(int unsigned l, int unsigned i, logic [31:0] v);
        if (l == 0 || l > lv_top || i >= lv_size[l]) return;
        nodes[lv_base[l] + i] = v;
    endfunction

    function automatic logic [31:0] pick(logic [31:0] x, logic [31:0] y);
        if (max_mode) return (x >= y) ? x : y;
        return (x <= y) ? x : y;
    endfunction

    function automatic bit hits(logic [31:0] x, logic [31:0] v);
        return max_mode ? (x >= v) : (x <= v);
    endfunction

    function automatic void search(bit fwd, int unsigned start_i, logic [31:0] v,
                                   ref rsp_t r);
        int unsigned l, i;
        l = 0;
        i = start_i;
        forever
        begin
            if (i >= lv_size[l]) return;
            if (hits(node_rd(l, i), v)) break;
            if (fwd)
            begin
                if (i & 1) i++;
                else
                begin
                    if (l >= lv_top) return;
                    i >>= 1;
                    l++;
                end
            end
            else
            begin
                if (!(i & 1))
                begin
                    if (i == 0) return;
                    i--;
                end
                else
                begin
                    if (l >= lv_top) return;
                    i >>= 1;
                    l++;
                end
            end
        end
        while (l > 0)
        begin
            i *= 2;
            l--;
            if (fwd)
            begin
                if (!hits(node_rd(l, i), v) && i + 1 < lv_size[l]) i++;
            end
            else if (i + 1 < lv_size[l] && hits(node_rd(l, i + 1), v)) i++;
        end
        r.result_index = i[9:0];
        r.found = 1'b1;
    endfunction

    // returns 1 when the command yields a result
    function automatic bit tree_step(req_t q, output rsp_t r);
        int unsigned l, i, a, b;
        logic [31:0] c;
        r = '0;
        plan();
        a = q.index_a;
        b = q.index_b;
        case (q.cmd)
            CMD_WRITE:
            begin
                leaves[a] = q.value;
                if (a >= lv_size[0]) return 0;
                l = 0;
                while (l < lv_top)
                begin
                    c = ((a ^ 1) < lv_size[l]) ? pick(node_rd(l, a), node_rd(l, a ^ 1))
                                               : node_rd(l, a);
                    if (c == node_rd(l + 1, a >> 1)) break;
                    l++;
                    a >>= 1;
                    node_wr(l, a, c);
                end
                return 0;
            end
            CMD_BUILD:
            begin
                for (l = 1; l <= lv_top; l++)
                    for (i = 0; i < lv_size[l]; i++)
                        if (2 * i + 1 < lv_size[l - 1])
                            node_wr(l, i, pick(node_rd(l - 1, 2 * i),
                                               node_rd(l - 1, 2 * i + 1)));
                        else
                            node_wr(l, i, node_rd(l - 1, 2 * i));
                return 0;
            end
            CMD_QUERY:
            begin
                c = node_rd(0, a);
                if (b > lv_size[0]) b = lv_size[0];
                l = 0;
                while (a < b)
                begin
                    if (a & 1)
                    begin
                        c = pick(c, node_rd(l, a));
                        a++;
                    end
                    if (b & 1)
                    begin
                        b--;
                        c = pick(c, node_rd(l, b));
                    end
                    a >>= 1;
                    b >>= 1;
                    l++;
                end
                r.result_value = c;
                return 1;
            end
            CMD_FWD, CMD_BWD:
            begin
                search(q.cmd == CMD_FWD, a, q.value, r);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (answers.size() == 0)
                report("unexpected result", result, 0);
            else
            begin
                rsp_t w;
                w = answers.pop_front();
                if (result.result_value !== w.result_value)
                    report("result_value", result.result_value, w.result_value);
                if (result.result_index !== w.result_index)
                    report("result_index", result.result_index, w.result_index);
                if (result.found !== w.found)
                    report("found", result.found, w.found);
            end
        end
    end

    // start stays high after acceptance until a pause or a drain drops it
    task automatic issue(req_t q, bit typed, rsp_t want);
        rsp_t r;
        bit   has;
        if ($urandom_range(99) < send_idle)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        start <= 1'b1;
        req <= q;
        do @(posedge clk); while (busy);
        has = tree_step(q, r);
        if (has)
        begin
            if (typed && r !== want)
                report("typed row", r, want);
            answers.push_back(typed ? want : r);
        end
    endtask

    task automatic drain();
        int n;
        start <= 1'b0;
        n = 0;
        while (answers.size() != 0 && n < SETTLE)
        begin
            @(posedge clk);
            n++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic set_reg(logic idx, logic [10:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SIZE) tree_size = d;
        else max_mode = d[0];
    endtask

    function automatic req_t mk(logic [2:0] c, int a, int b, logic [31:0] v);
        req_t q;
        q.cmd = c;
        q.index_a = a[9:0];
        q.index_b = b[10:0];
        q.value = v;
        return q;
    endfunction

    function automatic rsp_t rs(logic [31:0] v, int i, bit f);
        rsp_t r;
        r.result_value = v;
        r.result_index = i[9:0];
        r.found = f;
        return r;
    endfunction

    typedef struct {
        req_t q;
        bit   typed;
        rsp_t want;
    } row_t;

    task automatic random_item(int unsigned sz);
        req_t q;
        int unsigned k;
        k = $urandom_range(99);
        q = '0;
        q.value = $urandom();
        if ($urandom_range(3) == 0) q.value = $urandom_range(20);
        if (k < 30) q.cmd = CMD_WRITE;
        else if (k < 35) q.cmd = CMD_BUILD;
        else if (k < 55) q.cmd = CMD_QUERY;
        else if (k < 75) q.cmd = CMD_FWD;
        else if (k < 97) q.cmd = CMD_BWD;
        else q.cmd = 3'($urandom_range(5, 7));
        q.index_a = ($urandom_range(9) == 0) ? 10'($urandom()) : 10'($urandom_range(sz));
        q.index_b = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                              : 11'($urandom_range(sz + 1));
        issue(q, 1'b0, '0);
    endtask

    initial
    begin
        row_t rows [$];
        int unsigned sizes [6];
        int ph;
        for (int i = 0; i < LEAVES; i++) leaves[i] = '0;
        for (int i = 0; i < LEAVES + 40; i++) nodes[i] = '0;
        tree_size = 11'd1024;
        max_mode = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back('{mk(CMD_QUERY, 0, 1024, 0), 1, rs(0, 0, 0)});
        rows.push_back('{mk(CMD_FWD, 0, 0, 0), 1, rs(0, 0, 1)});
        rows.push_back('{mk(CMD_BWD, 1023, 0, 0), 1, rs(0, 1023, 1)});
        rows.push_back('{mk(CMD_WRITE, 5, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk(CMD_WRITE, 1023, 0, 32'h8000_0001), 0, '0});
        rows.push_back('{mk(CMD_QUERY, 5, 5, 0), 1, rs(32'hFFFF_FFFF, 0, 0)});
        rows.push_back('{mk(CMD_QUERY, 1023, 2047, 0), 1, rs(32'h8000_0001, 0, 0)});
        rows.push_back('{mk(CMD_FWD, 5, 0, 32'h7FFF_FFFF), 0, '0});
        rows.push_back('{mk(CMD_BWD, 0, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk(7, 3, 3, 3), 0, '0});
        rows.push_back('{mk(5, 0, 0, 0), 0, '0});
        foreach (rows[i]) issue(rows[i].q, rows[i].typed, rows[i].want);

        // small tree, max mode, stale then rebuilt
        set_reg(REG_SIZE, 11'd7);
        set_reg(REG_MODE, 1'b1);
        issue(mk(CMD_QUERY, 0, 7, 0), 1'b0, '0);
        issue(mk(CMD_BWD, 6, 0, 1), 1'b0, '0);
        issue(mk(CMD_BUILD, 0, 0, 0), 1'b0, '0);
        issue(mk(CMD_WRITE, 6, 0, 32'd9), 1'b0, '0);
        issue(mk(CMD_WRITE, 20, 0, 32'd9), 1'b0, '0);
        issue(mk(CMD_FWD, 0, 0, 32'd9), 1'b0, '0);
        issue(mk(CMD_BWD, 6, 0, 32'd9), 1'b0, '0);
        issue(mk(CMD_FWD, 8, 0, 32'd0), 1'b0, '0);
        issue(mk(CMD_QUERY, 0, 1024, 0), 1'b0, '0);
        set_reg(REG_SIZE, 11'd0);
        issue(mk(CMD_BUILD, 0, 0, 0), 1'b0, '0);
        issue(mk(CMD_QUERY, 0, 1, 0), 1'b0, '0);
        set_reg(REG_SIZE, 11'd2047);
        issue(mk(CMD_BUILD, 0, 0, 0), 1'b0, '0);
        issue(mk(CMD_FWD, 0, 0, 32'd9), 1'b0, '0);

        sizes = '{1, 2, 5, 13, 64, 1024};
        for (ph = 0; ph < 12; ph++)
        begin
            int unsigned sz;
            case (ph % 4)
                0: send_idle = 0;
                1: send_idle = 84;
                2: send_idle = 38;
                default: send_idle = 0;
            endcase
            sz = sizes[$urandom_range(5)];
            set_reg(REG_SIZE, 11'(sz));
            set_reg(REG_MODE, 1'($urandom()));
            issue(mk(CMD_BUILD, 0, 0, 0), 1'b0, '0);
            repeat (53) random_item(sz);
        end
        drain();
        if (errors == 0 && answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
